FILE: rtl/core/cisp_pkg.sv
// ----------------------------------------------------------------------------
// cisp_pkg
// types and constants shared by the instruction stream parser
// ----------------------------------------------------------------------------
package cisp_pkg;

    localparam int LEN_W  = 21;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 2;
    localparam int GRP_W  = 7;

    // number of varint bytes seen before the one that must end the varint
    localparam logic [CNT_W-1:0] VARINT_LAST_CNT = 2'd2;

    // byte tags of a result transaction
    localparam logic [KIND_W-1:0] KIND_PROG     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACC_LEN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACC      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA_LEN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd4;

    typedef enum logic [2:0] {
        PH_PROG     = 3'd0,
        PH_ACC_LEN  = 3'd1,
        PH_ACC      = 3'd2,
        PH_DATA_LEN = 3'd3,
        PH_DATA     = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_out;
        logic [LEN_W-1:0]  decoded_length;
        logic              length_done;
        logic              record_done;
        logic              truncated;
    } t_out;

endpackage

FILE: rtl/core/cisp_parser.sv
// ----------------------------------------------------------------------------
// cisp_parser
// record state machine: tags one byte per enable and updates the parse state
// ----------------------------------------------------------------------------
module cisp_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cisp_pkg::t_in i_item,
    output cisp_pkg::t_out o_res
);
    import cisp_pkg::*;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [LEN_W-1:0]   r_acc,   n_acc;
    logic [LEN_W-1:0]   r_rem,   n_rem;

    logic [LEN_W-1:0]   grp_pos;
    logic [LEN_W-1:0]   len_val;
    logic               len_more;
    logic [LEN_W-1:0]   rem_dec;

    // place the 7-bit group of this varint byte
    always_comb begin
        case (r_cnt)
            2'd0:    grp_pos = {14'd0, i_item.byte_in[GRP_W-1:0]};
            2'd1:    grp_pos = {7'd0, i_item.byte_in[GRP_W-1:0], 7'd0};
            default: grp_pos = {i_item.byte_in[GRP_W-1:0], 14'd0};
        endcase
    end

    assign len_val  = r_acc | grp_pos;
    assign len_more = i_item.byte_in[BYTE_W-1] && (r_cnt < VARINT_LAST_CNT);
    assign rem_dec  = r_rem - {{(LEN_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_rem   = r_rem;

        o_res                = '0;
        o_res.byte_out       = i_item.byte_in;

        unique case (r_phase)
            PH_ACC_LEN, PH_DATA_LEN: begin
                o_res.kind = (r_phase == PH_ACC_LEN) ? KIND_ACC_LEN : KIND_DATA_LEN;
                if (len_more) begin
                    n_cnt = r_cnt + 2'd1;
                    n_acc = len_val;
                end else begin
                    n_cnt                = '0;
                    n_acc                = '0;
                    o_res.length_done    = 1'b1;
                    o_res.decoded_length = len_val;
                    if (len_val == '0) begin
                        if (r_phase == PH_ACC_LEN) begin
                            n_phase = PH_DATA_LEN;
                        end else begin
                            o_res.record_done = 1'b1;
                            n_phase           = PH_PROG;
                        end
                    end else begin
                        n_rem   = len_val;
                        n_phase = (r_phase == PH_ACC_LEN) ? PH_ACC : PH_DATA;
                    end
                end
            end
            PH_ACC: begin
                o_res.kind = KIND_ACC;
                n_rem      = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_DATA_LEN;
                end
            end
            PH_DATA: begin
                o_res.kind = KIND_DATA;
                n_rem      = rem_dec;
                if (rem_dec == '0) begin
                    o_res.record_done = 1'b1;
                    n_phase           = PH_PROG;
                end
            end
            default: begin
                o_res.kind = KIND_PROG;
                n_cnt      = '0;
                n_acc      = '0;
                n_rem      = '0;
                n_phase    = PH_ACC_LEN;
            end
        endcase

        // buffer ended before the record did
        if (i_item.last_byte && !o_res.record_done) begin
            o_res.truncated = 1'b1;
            n_phase         = PH_PROG;
            n_cnt           = '0;
            n_acc           = '0;
            n_rem           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PROG;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: rtl/core/cisp_out_queue.sv
// ----------------------------------------------------------------------------
// cisp_out_queue
// two-entry result queue that decouples the parser from the receiver
// ----------------------------------------------------------------------------
module cisp_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cisp_pkg::t_out i_push_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_ready,
    output cisp_pkg::t_out o_data
);
    import cisp_pkg::*;

    t_out       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop    ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/core/compact_instruction_stream_parser.sv
// ----------------------------------------------------------------------------
// compact_instruction_stream_parser
// tags each byte of a buffer of length-prefixed instruction records
// ----------------------------------------------------------------------------
// usage
//   input channel  i_valid / o_ready / i_data: one buffer byte per transaction,
//                  with last_byte marking the final byte of the buffer
//   output channel o_valid / i_ready / o_data: exactly one result transaction
//                  per input transaction, in order, with the byte's role,
//                  the decoded varint length and record / truncation flags
//   path           from input acceptance to o_valid the byte is held in the
//                  input register, then passes through the parser into the
//                  result queue, which drives o_valid; while the queue is full
//                  the byte waits in the input register
//   throughput     1 transaction per cycle while the queue is not full; the parser
//                  state update is a single short pass from input register to queue
//   stall          a two-entry result queue sits behind the parser; o_ready
//                  comes from registers only and drops once the queue is full
//                  and the input register holds a waiting byte
//   reset          synchronous active low; parser returns to expecting a
//                  program index, the input register and queue are emptied
//   truncation     if last_byte arrives mid-record the result carries
//                  truncated and the next byte starts a new record
// ----------------------------------------------------------------------------
module compact_instruction_stream_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cisp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output cisp_pkg::t_out o_data
);
    import cisp_pkg::*;

    // input register
    logic  r_in_valid, n_in_valid;
    t_in   r_in_data;

    logic  q_full;
    logic  fire;
    t_out  step_res;

    // byte moves from the input register through the parser into the queue
    assign fire    = r_in_valid && !q_full;
    // room for a new byte whenever the register is empty or drains this cycle
    assign o_ready = !r_in_valid || !q_full;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_data <= i_data;
        end
    end

    // parse state advances only when the byte is committed to the queue
    cisp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (fire),
        .i_item  (r_in_data),
        .o_res   (step_res)
    );

    cisp_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fire),
        .i_push_data (step_res),
        .o_full      (q_full),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

FILE: rtl/core/cisp_checker.sv
// ----------------------------------------------------------------------------
// cisp_checker
// port-level checks for the instruction stream parser
// ----------------------------------------------------------------------------
module cisp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input cisp_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_ready,
    input cisp_pkg::t_out o_data
);
    import cisp_pkg::*;

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("input changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // only length bytes complete a varint
    a_len_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.length_done |->
            (o_data.kind == KIND_ACC_LEN) || (o_data.kind == KIND_DATA_LEN))
        else $error("length_done on a non-length byte");

    // a completed record is never truncated, and a length is only shown when done
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.record_done && o_data.truncated)
            && (o_data.length_done || (o_data.decoded_length == '0)))
        else $error("inconsistent result flags");

endmodule

bind compact_instruction_stream_parser cisp_checker u_cisp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
